// ===== hdl/pbr_pkg.sv =====
// Package for the polynomial bisection root unit: codes, widths and types.
// No dependencies.
package pbr_pkg;
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int LIMIT_W = 8;
   localparam int TOL_W = 31;
   localparam int POW_W = 4;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SOLVE = 1'b1;

   localparam logic [1:0] STOP_TOL = 2'd0;
   localparam logic [1:0] STOP_ZERO = 2'd1;
   localparam logic [1:0] STOP_LIMIT = 2'd2;

   localparam logic CSR_LIMIT = 1'b0;
   localparam logic CSR_TOL = 1'b1;

   typedef logic signed [DATA_W-1:0] word_type;

   // control between the sequencer and the evaluator
   typedef struct packed {
      logic start;
      logic signed [DATA_W-1:0] x;
   } eval_req_type;

   typedef struct packed {
      logic done;
      logic signed [DATA_W-1:0] y;
   } eval_rsp_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
      logic signed [DATA_W+1:0] hi;
      logic signed [DATA_W+1:0] lo;
      hi = {{3{1'b0}}, {(DATA_W-1){1'b1}}};
      lo = {{3{1'b1}}, {(DATA_W-1){1'b0}}};
      if (v > hi) return hi[DATA_W-1:0];
      else if (v < lo) return lo[DATA_W-1:0];
      else return v[DATA_W-1:0];
   endfunction
endpackage

// ===== hdl/pbr_eval.sv =====
// Horner evaluator with a bit-serial shift-and-add multiplier.
// Depends on pbr_pkg. One multiplier bit per cycle; each Horner step is a multiplier pass and an add.
module pbr_eval #(
   parameter int MAX_DEGREE = 8
) (
   input  logic clock,
   input  logic reset,
   input  pbr_pkg::eval_req_type req,
   output pbr_pkg::eval_rsp_type rsp,
   output logic [$clog2(MAX_DEGREE+1)-1:0] rd_index,
   input  logic signed [pbr_pkg::DATA_W-1:0] rd_coef
);
   import pbr_pkg::*;
   localparam int IDX_W = $clog2(MAX_DEGREE+1);
   localparam int PROD_W = 2*DATA_W;
   localparam int BIT_W = $clog2(DATA_W+1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_MUL = 2'd2;
   localparam logic [1:0] ST_ADD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] y_ff, y_in;
   logic [DATA_W-1:0] mshift_ff, mshift_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic done_ff, done_in;
   logic signed [PROD_W-1:0] addend;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [DATA_W-1:0] p_sat;

   assign rd_index = idx_ff;

   always_comb begin
      // multiplier bit i has weight 2^i, and bit 31 carries -2^31
      addend = PROD_W'(x_ff) <<< bit_ff;
      prod_sh = acc_ff >>> FRAC_W;
      if (prod_sh > PROD_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
         p_sat = {1'b0, {(DATA_W-1){1'b1}}};
      else if (prod_sh < -(PROD_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) - 1)
         p_sat = {1'b1, {(DATA_W-1){1'b0}}};
      else
         p_sat = prod_sh[DATA_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      bit_in = bit_ff;
      x_in = x_ff;
      y_in = y_ff;
      mshift_in = mshift_ff;
      acc_in = acc_ff;
      done_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               x_in = req.x;
               idx_in = IDX_W'(MAX_DEGREE);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            y_in = rd_coef;
            if (idx_ff == '0) begin
               done_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
               mshift_in = rd_coef;
               acc_in = '0;
               bit_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // y is the multiplier, taken one bit a cycle from the shift register
            if (mshift_ff[0]) begin
               if (bit_ff == BIT_W'(DATA_W-1)) acc_in = acc_ff - addend;
               else acc_in = acc_ff + addend;
            end
            mshift_in = mshift_ff >> 1;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_W'(DATA_W-1)) state_in = ST_ADD;
         end
         ST_ADD: begin
            y_in = sat32({{2{p_sat[DATA_W-1]}}, p_sat} + {{2{rd_coef[DATA_W-1]}}, rd_coef});
            if (idx_ff == '0) begin
               done_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
               mshift_in = sat32({{2{p_sat[DATA_W-1]}}, p_sat}
                                 + {{2{rd_coef[DATA_W-1]}}, rd_coef});
               acc_in = '0;
               bit_in = '0;
               state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      bit_ff <= bit_in;
      x_ff <= x_in;
      y_ff <= y_in;
      mshift_ff <= mshift_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.y = y_ff;
endmodule

// ===== hdl/polynomial_bisection_root_unit.sv =====
// Top level of the polynomial bisection root unit: coefficient store,
// bisection sequencer, result strobe. Depends on pbr_pkg and pbr_eval.
//
// A load item (func 0) is taken without making the block busy. A solve item
// runs up to iteration_limit bisection steps. Each step evaluates the
// polynomial at the midpoint and, unless it stops, at the lower end. Each
// evaluation runs through the bit-serial multiplier of pbr_eval: one
// coefficient load, then a multiplier pass and an add for each further
// coefficient, then the done flag. busy stays high until the result strobe;
// the result is shown for one cycle on rsp_valid and cannot be held off.
module polynomial_bisection_root_unit #(
   parameter int MAX_DEGREE = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_func,
   input  logic [pbr_pkg::POW_W-1:0] req_coef_power,
   input  logic signed [pbr_pkg::DATA_W-1:0] req_coef_value,
   input  logic signed [pbr_pkg::DATA_W-1:0] req_low_end,
   input  logic signed [pbr_pkg::DATA_W-1:0] req_high_end,
   output logic rsp_valid,
   output logic signed [pbr_pkg::DATA_W-1:0] rsp_root,
   output logic [pbr_pkg::LIMIT_W-1:0] rsp_iterations_used,
   output logic [1:0] rsp_stop_reason,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [pbr_pkg::TOL_W-1:0] csr_wdata
);
   import pbr_pkg::*;
   localparam int IDX_W = $clog2(MAX_DEGREE+1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MID = 3'd1;
   localparam logic [2:0] ST_WMID = 3'd2;
   localparam logic [2:0] ST_WLO = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic signed [DATA_W-1:0] coef_ff [MAX_DEGREE+1];
   logic [LIMIT_W-1:0] limit_ff;
   logic [TOL_W-1:0] tol_ff;
   logic signed [DATA_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, fmid_ff, fmid_in;
   logic [LIMIT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] reason_ff, reason_in;
   logic half_small_ff, half_small_in;
   logic valid_ff, valid_in;
   eval_req_type ereq;
   eval_rsp_type ersp;
   logic [IDX_W-1:0] rd_index;
   logic signed [DATA_W-1:0] rd_coef;
   logic signed [DATA_W:0] sum_w, diff_w;
   logic accept;

   assign accept = start && !busy;
   assign rd_coef = coef_ff[rd_index];
   assign sum_w = {lo_ff[DATA_W-1], lo_ff} + {hi_ff[DATA_W-1], hi_ff};
   assign diff_w = {hi_ff[DATA_W-1], hi_ff} - {lo_ff[DATA_W-1], lo_ff};

   pbr_eval #(.MAX_DEGREE(MAX_DEGREE)) u_eval (
      .clock(clock), .reset(reset), .req(ereq), .rsp(ersp),
      .rd_index(rd_index), .rd_coef(rd_coef)
   );

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      fmid_in = fmid_ff;
      cnt_in = cnt_ff;
      reason_in = reason_ff;
      half_small_in = half_small_ff;
      valid_in = 1'b0;
      ereq.start = 1'b0;
      ereq.x = mid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_SOLVE) begin
               lo_in = req_low_end;
               hi_in = req_high_end;
               cnt_in = '0;
               mid_in = '0;
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            if (cnt_ff >= limit_ff) begin
               reason_in = STOP_LIMIT;
               state_in = ST_DONE;
            end else begin
               mid_in = sum_w[DATA_W:1];
               // half is floor(diff/2); half < tol with tol >= 0
               half_small_in = diff_w[DATA_W] ||
                               ({1'b0, diff_w[DATA_W-1:1]} < {1'b0, tol_ff});
               cnt_in = cnt_ff + 1'b1;
               ereq.start = 1'b1;
               ereq.x = sum_w[DATA_W:1];
               state_in = ST_WMID;
            end
         end
         ST_WMID: begin
            if (ersp.done) begin
               fmid_in = ersp.y;
               if (half_small_ff) begin
                  reason_in = STOP_TOL;
                  state_in = ST_DONE;
               end else if (ersp.y == '0) begin
                  reason_in = STOP_ZERO;
                  state_in = ST_DONE;
               end else begin
                  ereq.start = 1'b1;
                  ereq.x = lo_ff;
                  state_in = ST_WLO;
               end
            end
         end
         ST_WLO: begin
            if (ersp.done) begin
               if (ersp.y != '0 && (ersp.y[DATA_W-1] != fmid_ff[DATA_W-1]))
                  hi_in = mid_ff;
               else
                  lo_in = mid_ff;
               state_in = ST_MID;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         limit_ff <= LIMIT_W'(50);
         tol_ff <= TOL_W'(66);
         for (int i = 0; i <= MAX_DEGREE; i++) coef_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_we && csr_index == CSR_LIMIT) limit_ff <= csr_wdata[LIMIT_W-1:0];
         if (csr_we && csr_index == CSR_TOL) tol_ff <= csr_wdata;
         if (accept && req_func == FUNC_LOAD &&
             {1'b0, req_coef_power} <= (POW_W+1)'(MAX_DEGREE))
            coef_ff[IDX_W'(req_coef_power)] <= req_coef_value;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      fmid_ff <= fmid_in;
      cnt_ff <= cnt_in;
      reason_ff <= reason_in;
      half_small_ff <= half_small_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_root = mid_ff;
   assign rsp_iterations_used = cnt_ff;
   assign rsp_stop_reason = reason_ff;
endmodule

// ===== hdl/pbr_checker.sv =====
// Port-level checks for the polynomial bisection root unit, with bind.
// Depends on pbr_pkg.
module pbr_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_valid,
   input logic [1:0] rsp_stop_reason,
   input logic [7:0] rsp_iterations_used
);
   import pbr_pkg::*;

   a_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_stop_reason == STOP_TOL || rsp_stop_reason == STOP_ZERO ||
                     rsp_stop_reason == STOP_LIMIT))
      else $error("bad stop reason");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_LOAD) |=> !busy)
      else $error("load item left block busy");
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_SOLVE) |=> busy)
      else $error("solve item not taken");
   a_valid_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe too long");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_reason != STOP_LIMIT) |-> rsp_iterations_used != 8'd0)
      else $error("early stop without iteration");
endmodule

bind polynomial_bisection_root_unit pbr_checker u_pbr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_func(req_func),
   .rsp_valid(rsp_valid), .rsp_stop_reason(rsp_stop_reason),
   .rsp_iterations_used(rsp_iterations_used)
);
